// ===== src/ftda_pkg.sv =====
// Shared types, character codes and power-of-ten table for the fixed-point to text block.
package ftda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [2:0] MAX_FRAC   = 3'd6;
    localparam logic [2:0] FD_RESET   = 3'd2;
    localparam logic [2:0] INT_TOP_P  = 3'd4;

    localparam int XW = 20;

    typedef enum logic [1:0] {
        CH_MINUS,
        CH_DIGIT,
        CH_POINT
    } char_kind_t;

    typedef struct packed {
        logic       load;
        logic       scale;
        logic       step;
        logic       frac_load;
        logic       out_write;
        char_kind_t out_kind;
        logic       out_last;
    } ftda_cmd_t;

    typedef struct packed {
        logic       neg;
        logic       p_zero;
        logic       emit_int;
        logic       fd_zero;
        logic       out_free;
    } ftda_sts_t;

    function automatic logic [XW-1:0] pow10(input logic [2:0] p);
        logic [XW-1:0] r;
        case (p)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/fixed_to_decimal_ascii_top.sv =====
// Top level: signed Q15.16 value in, decimal ASCII text out one character per transaction.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  s_axis    | s_axis_tvalid/tready   | tdata[31:0] value (Q15.16, signed)
//  m_axis    | m_axis_tvalid/tready   | tdata[7:0] character, tlast last
//  cfg       | cfg_we                 | cfg_wdata[2:0] frac_digits
//
// Each value is stepped by the digit sequencer: a load step, the sign step, five integer places
// and, unless frac_digits is zero, the point and one step per fraction digit (clamped to six).
// A new value is accepted only in idle; the last character may still wait in the output register.
// Output back-pressure holds the sequencer on every character it has to emit.
// Reset is asynchronous, active low; frac_digits resets to 2.
module fixed_to_decimal_ascii_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata
);
    import ftda_pkg::*;

    ftda_cmd_t cmd;
    ftda_sts_t sts;

    ftda_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ftda_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_value      (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/ftda_datapath.sv =====
// Datapath: magnitude, fraction scaling, digit extraction and output register.
module ftda_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_wdata,
    input  logic [31:0]       in_value,
    input  ftda_pkg::ftda_cmd_t cmd,
    output ftda_pkg::ftda_sts_t sts,
    input  logic              m_axis_tready,
    output logic              m_axis_tvalid,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast
);
    import ftda_pkg::*;

    logic [2:0]    fd_cfg_reg;
    logic          neg_reg;
    logic [15:0]   ipart_reg;
    logic [15:0]   frac_reg;
    logic [2:0]    fd_reg;
    logic [XW-1:0] scaled_reg;
    logic [XW-1:0] x_reg;
    logic [2:0]    p_reg;
    logic          started_reg;
    logic          valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;

    logic [31:0]   mag;
    logic [35:0]   prod;
    logic [XW-1:0] pw;
    logic [3:0]    digit;
    logic [XW-1:0] sub;
    logic          out_free;

    assign mag  = in_value[31] ? (32'd0 - in_value) : in_value;
    assign prod = 36'(frac_reg) * 36'(pow10(fd_reg));
    assign pw   = pow10(p_reg);

    // digit = largest k with k * 10^p <= x
    always_comb
    begin
        digit = 4'd0;
        sub   = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (x_reg >= XW'(pw * XW'(k)))
            begin
                digit = 4'(k);
                sub   = XW'(pw * XW'(k));
            end
        end
    end

    assign out_free = !valid_reg || m_axis_tready;

    assign sts.neg      = neg_reg;
    assign sts.p_zero   = (p_reg == 3'd0);
    assign sts.emit_int = (digit != 4'd0) || started_reg || (p_reg == 3'd0);
    assign sts.fd_zero  = (fd_reg == 3'd0);
    assign sts.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_cfg_reg <= FD_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fd_cfg_reg <= cfg_wdata;
            end
            if (cmd.out_write)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg   <= in_value[31];
            ipart_reg <= mag[31:16];
            frac_reg  <= mag[15:0];
            fd_reg    <= (fd_cfg_reg > MAX_FRAC) ? MAX_FRAC : fd_cfg_reg;
        end
        if (cmd.scale)
        begin
            scaled_reg  <= prod[35:16];
            x_reg       <= XW'(ipart_reg);
            p_reg       <= INT_TOP_P;
            started_reg <= 1'b0;
        end
        else if (cmd.frac_load)
        begin
            x_reg <= scaled_reg;
            p_reg <= fd_reg - 3'd1;
        end
        else if (cmd.step)
        begin
            x_reg       <= x_reg - sub;
            p_reg       <= p_reg - 3'd1;
            started_reg <= started_reg || (digit != 4'd0);
        end
        if (cmd.out_write)
        begin
            last_reg <= cmd.out_last;
            case (cmd.out_kind)
                CH_MINUS: char_reg <= CHAR_MINUS;
                CH_POINT: char_reg <= CHAR_POINT;
                CH_DIGIT: char_reg <= CHAR_ZERO + 8'(digit);
                default:  char_reg <= CHAR_ZERO;
            endcase
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    a_write_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> out_free)
        else $error("output register overwritten while holding a transaction");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (digit < 4'd10) && (x_reg - sub < pw))
        else $error("digit extraction left a remainder above the place value");

    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("waiting output transaction changed before it was taken");
`endif

endmodule

// ===== src/ftda_ctrl.sv =====
// Controller: sequences sign, integer digits, point and fraction digits.
module ftda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  ftda_pkg::ftda_sts_t sts,
    output ftda_pkg::ftda_cmd_t cmd
);
    import ftda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                cmd.scale = 1'b1;
                if (!sts.neg)
                begin
                    state_next = ST_INT;
                end
                else if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_kind  = CH_MINUS;
                    state_next    = ST_INT;
                end
            end
            ST_INT:
            begin
                if (!sts.emit_int || sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.emit_int)
                    begin
                        cmd.out_write = 1'b1;
                        cmd.out_kind  = CH_DIGIT;
                        cmd.out_last  = sts.p_zero && sts.fd_zero;
                    end
                    if (sts.p_zero)
                    begin
                        state_next = sts.fd_zero ? ST_IDLE : ST_POINT;
                    end
                end
            end
            ST_POINT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_kind  = CH_POINT;
                    cmd.frac_load = 1'b1;
                    state_next    = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (sts.out_free)
                begin
                    cmd.step      = 1'b1;
                    cmd.out_write = 1'b1;
                    cmd.out_kind  = CH_DIGIT;
                    cmd.out_last  = sts.p_zero;
                    if (sts.p_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_load_enters_sign: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SIGN)
        else $error("accepted value did not start the sign step");

    a_int_ends_at_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INT) && cmd.step && sts.p_zero |=> state_reg != ST_INT)
        else $error("integer phase ran past the units digit");

    a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write && cmd.out_last |=> state_reg == ST_IDLE)
        else $error("last character flagged before the text was finished");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Testbench for fixed_to_decimal_ascii_top: Q15.16 values in, checked decimal text out.
`timescale 1ns / 1ps

module tb_top;
    import ftda_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 16;
    localparam int RANDOM_NUMS = 156;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [2:0]  digits;
        logic [31:0] value;
        string       text;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;

    text_char_t  char_q [$];
    logic [2:0]  frac_cfg = FD_RESET;
    int          fail_cnt = 0;
    int          chars_seen = 0;
    int          values_sent = 0;
    int          settings_used = 1;
    int          quiet_cnt = 0;
    int          hold_cnt = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    // blank text means the predictor supplies the expected characters
    dir_row_t dir_rows [24] = '{
        '{3'd2, 32'h0000_0000, "0.00"},
        '{3'd2, 32'h0001_0000, "1.00"},
        '{3'd2, 32'h7FFF_FFFF, "32767.99"},
        '{3'd2, 32'h8000_0000, "-32768.00"},
        '{3'd2, 32'hFFFF_FFFF, "-0.00"},
        '{3'd2, 32'hFFFF_8000, "-0.50"},
        '{3'd2, 32'h0000_FFFF, "0.99"},
        '{3'd2, 32'h3039_5A1D, ""},
        '{3'd2, 32'hC000_4000, ""},
        '{3'd0, 32'h7FFF_FFFF, "32767"},
        '{3'd0, 32'h8000_0000, "-32768"},
        '{3'd0, 32'h0000_0000, "0"},
        '{3'd0, 32'hFFFF_FFFF, "-0"},
        '{3'd0, 32'h0009_FFFF, "9"},
        '{3'd6, 32'h0000_FFFF, "0.999984"},
        '{3'd6, 32'h0000_0001, "0.000015"},
        '{3'd6, 32'h8000_0000, "-32768.000000"},
        '{3'd6, 32'h8000_0001, "-32767.999984"},
        '{3'd7, 32'h0000_8000, "0.500000"},
        '{3'd7, 32'hFFFF_0000, "-1.000000"},
        '{3'd1, 32'h0000_4000, "0.2"},
        '{3'd1, 32'h000A_1999, ""},
        '{3'd3, 32'h0064_0000, "100.000"},
        '{3'd5, 32'hFFF6_0000, "-10.00000"}
    };

    fixed_to_decimal_ascii_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void queue_text(input logic [7:0] txt [$]);
        text_char_t c;
        foreach (txt[i])
        begin
            c.ch   = txt[i];
            c.last = (i == txt.size() - 1);
            char_q.push_back(c);
        end
    endfunction

    function automatic void spell_value(input logic [31:0] v);
        logic              neg;
        logic [31:0]       mag;
        logic [15:0]       ipart;
        logic [15:0]       fpart;
        logic [2:0]        fd;
        longint unsigned   p;
        longint unsigned   scaled;
        logic [7:0]        txt [$];
        logic [7:0]        digs [$];
        neg   = v[31];
        mag   = neg ? (32'd0 - v) : v;
        ipart = mag[31:16];
        fpart = mag[15:0];
        fd    = (frac_cfg > MAX_FRAC) ? MAX_FRAC : frac_cfg;
        if (neg)
            txt.push_back(CHAR_MINUS);
        if (ipart == 0)
            txt.push_back(CHAR_ZERO);
        while (ipart != 0)
        begin
            digs.push_front(8'(CHAR_ZERO + ipart % 10));
            ipart = ipart / 10;
        end
        txt = {txt, digs};
        if (fd != 0)
        begin
            p = 1;
            repeat (fd) p = p * 10;
            scaled = (64'(fpart) * p) >> 16;
            txt.push_back(CHAR_POINT);
            digs = {};
            repeat (fd)
            begin
                digs.push_front(8'(CHAR_ZERO + scaled % 10));
                scaled = scaled / 10;
            end
            txt = {txt, digs};
        end
        queue_text(txt);
    endfunction

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = idle_len(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        values_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_digits(input logic [2:0] d);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frac_cfg  = d;
        settings_used++;
    endtask

    // output side: random back-pressure with calm stretches
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cnt != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold_cnt = idle_len(rx_calm);
            end
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            chars_seen++;
            if (char_q.size() == 0)
            begin
                $error("unexpected character %h (last %b)", m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end
            else
            begin
                want = char_q.pop_front();
                if (m_axis_tdata !== want.ch)
                begin
                    $error("character: expected %h, got %h", want.ch, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cnt = 0;
            else
                quiet_cnt++;
            if (quiet_cnt == QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d characters pending",
                         QUIET_LIMIT, char_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0]  typed [$];
        logic [31:0] v;
        int          n;
        int          rnd_sent;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: reset setting first, then digit counts 0, 6, 7 (out of range), 1, 3 and 5
        for (int r = 0; r < $size(dir_rows); r++)
        begin
            if (dir_rows[r].digits != frac_cfg)
            begin
                drain();
                set_digits(dir_rows[r].digits);
            end
            send_value(dir_rows[r].value);
            if (dir_rows[r].text.len() == 0)
                spell_value(dir_rows[r].value);
            else
            begin
                typed = {};
                for (int k = 0; k < dir_rows[r].text.len(); k++)
                    typed.push_back(dir_rows[r].text[k]);
                queue_text(typed);
            end
        end

        // random phases, one digit setting each, sender drains before every write
        rnd_sent = 0;
        while (rnd_sent < RANDOM_NUMS)
        begin
            drain();
            set_digits(3'($urandom_range(0, 7)));
            tx_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(10, 30);
            if (n > RANDOM_NUMS - rnd_sent)
                n = RANDOM_NUMS - rnd_sent;
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0, 1: v = $urandom();
                    2:
                    begin
                        v = {16'($urandom_range(0, 20)), 16'($urandom())};
                        if ($urandom_range(0, 1) != 0)
                            v = 32'd0 - v;
                    end
                    3:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                        else
                            v = 32'h8000_0000 + $urandom_range(0, 3);
                    end
                    4: v = {{16{1'($urandom_range(0, 1))}}, 16'($urandom())};
                    default: v = {16'($urandom()), 16'h0000};
                endcase
                send_value(v);
                spell_value(v);
                rnd_sent++;
            end
        end

        drain();
        $display("covered %0d numbers over %0d digit settings, %0d characters checked",
                 values_sent, settings_used, chars_seen);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
